/* hw/rtl/crcfr_pkg.sv */
package crcfr_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 19;
  localparam int unsigned BODY_BYTES  = 15;
  localparam logic [4:0] POS_NODE       = 5'd1;
  localparam logic [4:0] POS_BODY_FIRST = 5'd2;
  localparam logic [4:0] POS_BODY_LAST  = 5'd16;
  localparam logic [4:0] POS_CRC        = 5'd17;
  localparam logic [4:0] POS_END        = 5'd18;

  // crc-8 settings
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // register indexes
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;
  localparam logic [1:0] CFG_OWN_NODE     = 2'd2;

  // register reset values
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'h55;
  localparam logic [1:0] OWN_NODE_RST     = 2'd1;

  // output widths
  localparam int unsigned OUT_DATA_W = 200;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_BAD_END = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_IGNORED = 2'd3
  } frame_status_t;

  // one completed frame, as classified by the front part
  typedef struct packed {
    logic                        end_ok;
    logic                        crc_ok;
    logic [7:0]                  node;
    logic [BODY_BYTES-1:0][7:0]  body;   // body[0] is frame position 2
  } frame_rec_t;

  // one crc step over a whole byte, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] d);
    logic [7:0] c;
    c = crc_in ^ d;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/crc8_frame_receiver.sv */
// Byte-serial frame receiver: waits for the start byte, collects a fixed
// 19-byte frame, checks the end byte and a CRC-8 (poly 0x31, init 0, msb
// first) over bytes 1 to 16, and gives one result item per completed frame
// with its status, big-endian fields and wrapping good/bad counters. One
// byte is taken every cycle; the position counter and the per-byte crc
// update in the front part set that figure. Finished frames pass through a
// two-entry queue to the back part, which holds the result in an output
// register, so the input stalls only on a closing byte when the queue is
// full. A result is held in a queue entry and then in the output register.
module crc8_frame_receiver
  import crcfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sender_node, heading_tenths, pitch_tenths, roll_tenths,
  // heading_err_tenths, turn_rate_tenths, accel_hundredths, health_byte,
  // stamp_ms, good_frames, bad_frames, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,   // frame_status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  logic [7:0] start_marker_r;
  logic [7:0] end_marker_r;
  logic [1:0] own_node_r;
  logic       rec_valid;
  logic       q_push_ready;
  frame_rec_t rec_in, rec_out;
  logic       q_valid, q_ready;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
      own_node_r     <= OWN_NODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker_r <= cfg_data;
        CFG_END_MARKER:   end_marker_r   <= cfg_data;
        CFG_OWN_NODE:     own_node_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  crcfr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (in_tvalid),
    .byte_ready   (in_tready),
    .rx_byte      (in_tdata),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .rec_valid    (rec_valid),
    .rec_ready    (q_push_ready),
    .rec_o        (rec_in)
  );

  crcfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (rec_valid),
    .push_ready (q_push_ready),
    .push_rec   (rec_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_rec    (rec_out)
  );

  crcfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_valid),
    .rec_ready  (q_ready),
    .rec        (rec_out),
    .own_node   (own_node_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/crcfr_front.sv */
module crcfr_front
  import crcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] rx_byte,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  output logic       rec_valid,
  input  logic       rec_ready,
  output frame_rec_t rec_o
);

  logic                       in_frame_r, in_frame_nxt;
  logic [4:0]                 pos_r, pos_nxt;
  logic [7:0]                 crc_r, crc_nxt;
  logic                       crc_ok_r;
  logic [7:0]                 node_r;
  logic [BODY_BYTES-1:0][7:0] body_r;
  logic                       take;
  logic                       at_end;
  logic [3:0]                 body_idx;

  assign at_end     = in_frame_r && (pos_r == POS_END);
  // only the closing byte needs room in the queue
  assign byte_ready = !at_end || rec_ready;
  assign take       = byte_valid && byte_ready;
  assign body_idx   = 4'(pos_r - POS_BODY_FIRST);

  // position tracking
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    if (take) begin
      if (!in_frame_r) begin
        if (rx_byte == start_marker) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = POS_NODE;
        end
      end else if (at_end) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = 5'd0;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  // running crc over positions 1 to 16
  always_comb begin
    crc_nxt = crc_r;
    if (take && in_frame_r) begin
      if (pos_r == POS_NODE) begin
        crc_nxt = crc8_byte(CRC_INIT, rx_byte);
      end else if (pos_r <= POS_BODY_LAST) begin
        crc_nxt = crc8_byte(crc_r, rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= 5'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // frame byte capture
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (take && in_frame_r) begin
      if (pos_r == POS_NODE) begin
        node_r <= rx_byte;
      end
      if (pos_r >= POS_BODY_FIRST && pos_r <= POS_BODY_LAST) begin
        body_r[body_idx] <= rx_byte;
      end
      if (pos_r == POS_CRC) begin
        crc_ok_r <= (crc_r == rx_byte);
      end
    end
  end

  // record handed to the queue on the closing byte
  assign rec_valid    = at_end && byte_valid;
  assign rec_o.end_ok = (rx_byte == end_marker);
  assign rec_o.crc_ok = crc_ok_r;
  assign rec_o.node   = node_r;
  assign rec_o.body   = body_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_END)
    else $error("frame position out of range");
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> pos_r == 5'd0)
    else $error("position nonzero outside a frame");

endmodule

/* hw/rtl/crcfr_queue.sv */
module crcfr_queue
  import crcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_rec_t push_rec,
  output logic       pop_valid,
  input  logic       pop_ready,
  output frame_rec_t pop_rec
);

  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  frame_rec_t mem_r [2];
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue count overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step with count");

endmodule

/* hw/rtl/crcfr_back.sv */
module crcfr_back
  import crcfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rec_valid,
  output logic                  rec_ready,
  input  frame_rec_t            rec,
  input  logic [1:0]            own_node,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser
);

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r;
  logic [31:0]           good_r, good_nxt;
  logic [31:0]           bad_r, bad_nxt;
  frame_status_t         status;
  logic                  node_ok;
  logic                  pop;
  logic [15:0]           stamp_raw;
  logic [19:0]           stamp_ms;
  logic [7:0]            node_f, health_f;
  logic [15:0]           head_f, pitch_f, roll_f, herr_f, yaw_f, accel_f;
  logic [19:0]           stamp_f;

  assign rec_ready = !out_valid_r || out_tready;
  assign pop       = rec_valid && rec_ready;

  // frame verdict
  assign node_ok = (rec.node[7:2] == 6'd0) && (rec.node[1:0] != 2'd0) &&
                   (rec.node != {6'd0, own_node});
  always_comb begin
    priority if (!rec.end_ok) begin
      status = ST_BAD_END;
    end else if (!rec.crc_ok) begin
      status = ST_BAD_CRC;
    end else if (!node_ok) begin
      status = ST_IGNORED;
    end else begin
      status = ST_ACCEPT;
    end
  end

  // counters
  always_comb begin
    good_nxt = good_r;
    bad_nxt  = bad_r;
    if (pop) begin
      if (status == ST_ACCEPT) begin
        good_nxt = good_r + 32'd1;
      end
      if (status == ST_BAD_END || status == ST_BAD_CRC) begin
        bad_nxt = bad_r + 32'd1;
      end
    end
  end

  // timestamp times ten as shift and add
  assign stamp_raw = {rec.body[13], rec.body[14]};
  assign stamp_ms  = {1'b0, stamp_raw, 3'b000} + {3'b000, stamp_raw, 1'b0};

  // payload fields, zero unless accepted
  always_comb begin
    node_f   = 8'd0;
    head_f   = 16'd0;
    pitch_f  = 16'd0;
    roll_f   = 16'd0;
    herr_f   = 16'd0;
    yaw_f    = 16'd0;
    accel_f  = 16'd0;
    health_f = 8'd0;
    stamp_f  = 20'd0;
    if (status == ST_ACCEPT) begin
      node_f   = rec.node;
      head_f   = {rec.body[0], rec.body[1]};
      pitch_f  = {rec.body[2], rec.body[3]};
      roll_f   = {rec.body[4], rec.body[5]};
      herr_f   = {rec.body[6], rec.body[7]};
      yaw_f    = {rec.body[8], rec.body[9]};
      accel_f  = {rec.body[10], rec.body[11]};
      health_f = rec.body[12];
      stamp_f  = stamp_ms;
    end
    out_data_nxt = {4'd0, bad_nxt, good_nxt, stamp_f, health_f, accel_f, yaw_f,
                    herr_f, roll_f, pitch_f, head_f, node_f};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      good_r      <= 32'd0;
      bad_r       <= 32'd0;
    end else begin
      good_r <= good_nxt;
      bad_r  <= bad_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
      out_user_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_good_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && status == ST_ACCEPT) |=> good_r == $past(good_r) + 32'd1)
    else $error("good counter did not advance");
  a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> ($stable(good_r) && $stable(bad_r)))
    else $error("counter changed without a frame");

endmodule

/* sim/tb.sv */
module tb;
  import crcfr_pkg::*;

  localparam int FRAME_LEN      = 19;
  localparam int NODE_AT        = 1;
  localparam int CRC_FROM       = 1;
  localparam int CRC_TO         = 16;
  localparam int CRC_AT         = 17;
  localparam int END_AT         = 18;
  localparam logic [7:0] CRC8_POLY = 8'h31;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HALF_PHASE_BYTES = 165;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 300000;

  typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_t;

  typedef enum {FLAW_NONE, FLAW_END, FLAW_CRC, FLAW_BOTH} flaw_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    node;
    logic [15:0]   heading;
    logic [15:0]   pitch;
    logic [15:0]   roll;
    logic [15:0]   head_err;
    logic [15:0]   turn_rate;
    logic [15:0]   accel;
    logic [7:0]    health;
    logic [19:0]   stamp;
    logic [31:0]   good;
    logic [31:0]   bad;
  } frame_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  crc8_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // deframer state mirrored by the testbench
  logic [7:0]   rx_start;
  logic [7:0]   rx_end;
  logic [1:0]   rx_own;
  logic         rx_in_frame;
  logic [4:0]   rx_pos;
  frame_bytes_t rx_store;
  logic [31:0]  rx_good_cnt;
  logic [31:0]  rx_bad_cnt;

  frame_result_t expected_frames[$];
  logic [7:0]    rx_byte_q[$];
  int            queued_cnt;
  int            mismatches;
  int            send_idle_pct;
  int            recv_stall_pct;
  logic          in_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_err($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // crc-8 over frame positions 1..16, msb first
  function automatic logic [7:0] crc8_of(input frame_bytes_t f);
    logic [7:0] crc;
    logic [7:0] d;
    crc = 8'h00;
    for (int i = CRC_FROM; i <= CRC_TO; i++) begin
      d = f[i];
      for (int b = 0; b < 8; b++) begin
        if (crc[7] ^ d[7]) begin
          crc = {crc[6:0], 1'b0} ^ CRC8_POLY;
        end else begin
          crc = {crc[6:0], 1'b0};
        end
        d = d << 1;
      end
    end
    return crc;
  endfunction

  // one accepted byte through the deframer
  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0] node;
    if (!rx_in_frame) begin
      if (b == rx_start) begin
        rx_store[0] = b;
        rx_pos = 5'd1;
        rx_in_frame = 1'b1;
      end
    end else begin
      rx_store[rx_pos] = b;
      rx_pos = rx_pos + 5'd1;
      if (rx_pos == FRAME_LEN) begin
        r = '0;
        node = rx_store[NODE_AT];
        if (rx_store[END_AT] != rx_end) begin
          rx_bad_cnt++;
          r.status = ST_BAD_END;
        end else if (crc8_of(rx_store) != rx_store[CRC_AT]) begin
          rx_bad_cnt++;
          r.status = ST_BAD_CRC;
        end else if (node < 8'd1 || node > 8'd3 || node == {6'd0, rx_own}) begin
          r.status = ST_IGNORED;
        end else begin
          rx_good_cnt++;
          r.status    = ST_ACCEPT;
          r.node      = node;
          r.heading   = {rx_store[2], rx_store[3]};
          r.pitch     = {rx_store[4], rx_store[5]};
          r.roll      = {rx_store[6], rx_store[7]};
          r.head_err  = {rx_store[8], rx_store[9]};
          r.turn_rate = {rx_store[10], rx_store[11]};
          r.accel     = {rx_store[12], rx_store[13]};
          r.health    = rx_store[14];
          r.stamp     = {4'd0, rx_store[15], rx_store[16]} * 20'd10;
        end
        r.good = rx_good_cnt;
        r.bad  = rx_bad_cnt;
        expected_frames.push_back(r);
        rx_in_frame = 1'b0;
        rx_pos = 5'd0;
      end
    end
  endtask

  // input driver: new item or hold at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_byte_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted bytes, check result items
  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_MARKER: rx_start = cfg_data;
          CFG_END_MARKER:   rx_end = cfg_data;
          CFG_OWN_NODE:     rx_own = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          report_err("result item with no frame pending");
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_status", out_tuser, want.status);
          check_field("sender_node", out_tdata[7:0], want.node);
          check_field("heading_tenths", out_tdata[23:8], want.heading);
          check_field("pitch_tenths", out_tdata[39:24], want.pitch);
          check_field("roll_tenths", out_tdata[55:40], want.roll);
          check_field("heading_err_tenths", out_tdata[71:56], want.head_err);
          check_field("turn_rate_tenths", out_tdata[87:72], want.turn_rate);
          check_field("accel_hundredths", out_tdata[103:88], want.accel);
          check_field("health_byte", out_tdata[111:104], want.health);
          check_field("stamp_ms", out_tdata[131:112], want.stamp);
          check_field("good_frames", out_tdata[163:132], want.good);
          check_field("bad_frames", out_tdata[195:164], want.bad);
          check_field("zero fill", out_tdata[OUT_DATA_W-1:196], '0);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_byte_q.push_back(b);
    queued_cnt++;
  endtask

  // any byte that does not open a frame
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == rx_start);
    return b;
  endfunction

  // whole frame under the current markers; fill < 0 means random body
  task automatic queue_frame(input logic [7:0] node, input int fill, input flaw_t flaw);
    frame_bytes_t f;
    f[0] = rx_start;
    f[NODE_AT] = node;
    for (int i = 2; i <= CRC_TO; i++) begin
      f[i] = (fill < 0) ? 8'($urandom) : fill[7:0];
    end
    f[CRC_AT] = crc8_of(f);
    f[END_AT] = rx_end;
    if (flaw == FLAW_END || flaw == FLAW_BOTH) begin
      f[END_AT] = f[END_AT] ^ 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_CRC || flaw == FLAW_BOTH) begin
      f[CRC_AT] = f[CRC_AT] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < FRAME_LEN; i++) begin
      push_byte(f[i]);
    end
  endtask

  // mostly well-formed frames, some noise and cut-off frames
  task automatic queue_random(input int n);
    int stop;
    int pick;
    logic [7:0] node;
    flaw_t flaw;
    stop = queued_cnt + n;
    while (queued_cnt < stop) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) push_byte(noise_byte());
      end else if (pick < 14) begin
        push_byte(rx_start);
        repeat ($urandom_range(1, FRAME_LEN - 2)) push_byte(8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          node = 8'($urandom_range(1, 3));
        end else if (pick < 85) begin
          node = 8'd0;
        end else begin
          node = 8'($urandom_range(4, 255));
        end
        pick = $urandom_range(99);
        if (pick < 72) begin
          flaw = FLAW_NONE;
        end else if (pick < 84) begin
          flaw = FLAW_END;
        end else if (pick < 96) begin
          flaw = FLAW_CRC;
        end else begin
          flaw = FLAW_BOTH;
        end
        queue_frame(node, ($urandom_range(9) == 0) ? int'(rx_start) : -1, flaw);
      end
    end
  endtask

  // hold the sender until all pending frames have come out
  task automatic wait_idle();
    while (rx_byte_q.size() != 0 || in_tvalid || expected_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_MARKER;
    cfg_data = 8'd0;
    rx_start = START_MARKER_RST;
    rx_end = END_MARKER_RST;
    rx_own = OWN_NODE_RST;
    rx_in_frame = 1'b0;
    rx_pos = 5'd0;
    rx_store = '0;
    rx_good_cnt = 32'd0;
    rx_bad_cnt = 32'd0;
    queued_cnt = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // reset markers, no idling; directed cases first
          push_byte(8'h00);
          push_byte(8'hFF);
          queue_frame(8'd2, 8'h00, FLAW_NONE);
          queue_frame(8'd3, 8'hFF, FLAW_NONE);
          queue_frame(8'd2, 8'h80, FLAW_NONE);
          queue_frame(8'd3, 8'h7F, FLAW_NONE);
          queue_frame(8'd2, -1, FLAW_END);
          queue_frame(8'd3, -1, FLAW_CRC);
          // bad end byte wins over bad crc
          queue_frame(8'd2, -1, FLAW_BOTH);
          queue_frame(8'd0, -1, FLAW_NONE);
          queue_frame(8'd1, -1, FLAW_NONE);
          queue_frame(8'd4, -1, FLAW_NONE);
          queue_frame(8'hFF, -1, FLAW_NONE);
          // crc is checked before the node id
          queue_frame(rx_start, -1, FLAW_CRC);
          // start byte inside the frame is plain data
          queue_frame(8'd3, int'(rx_start), FLAW_NONE);
          // cut-off frame swallows the next one
          push_byte(rx_start);
          repeat (5) push_byte(8'($urandom));
          queue_frame(8'd2, -1, FLAW_NONE);
          wait_idle();
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
          write_reg(CFG_START_MARKER, 8'h00);
          write_reg(CFG_END_MARKER, 8'hFF);
          write_reg(CFG_OWN_NODE, 8'hFE);
          write_reg(CFG_UNUSED, 8'h5A);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
          write_reg(CFG_START_MARKER, 8'hFF);
          write_reg(CFG_END_MARKER, 8'h00);
          write_reg(CFG_OWN_NODE, 8'h00);
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
          write_reg(CFG_START_MARKER, 8'h7E);
          write_reg(CFG_END_MARKER, 8'h81);
          write_reg(CFG_OWN_NODE, 8'h03);
        end
      endcase
      queue_random(HALF_PHASE_BYTES);
      wait_idle();
      queue_random(HALF_PHASE_BYTES);
      wait_idle();
      // close an open frame before the markers change
      if (rx_in_frame) begin
        repeat (FRAME_LEN - rx_pos) push_byte(8'($urandom));
        wait_idle();
      end
    end

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
